>>> rtl/slp_pkg.sv
// Shared types, codes and character helpers for the symbol assignment line parser.
package slp_pkg;

  // Parse phases of one line
  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_IDENT     = 4'd1,
    PH_AFTER_ID  = 4'd2,
    PH_COLON     = 4'd3,
    PH_EQ        = 4'd4,
    PH_SIGN      = 4'd5,
    PH_PREFIX    = 4'd6,
    PH_DIGITS    = 4'd7,
    PH_AFTER_NUM = 4'd8,
    PH_COMMENT   = 4'd9,
    PH_SKIP      = 4'd10
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    K_IDENT    = 3'd0,
    K_DEFINED  = 3'd1,
    K_DROPPED  = 3'd2,
    K_SYNTAX   = 3'd3,
    K_MISS_EQ  = 3'd4,
    K_NUM_FMT  = 3'd5,
    K_TRAILING = 3'd6
  } kind_t;

  // Radix codes
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_UNUSED = 2'd3
  } radix_t;

  // Configuration register indexes
  localparam logic REG_COMMENT_CHAR = 1'b0;
  localparam logic REG_IGNORE       = 1'b1;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_PCT    = 8'd37;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_EQUALS = 8'd61;
  localparam logic [7:0] CH_UNDER  = 8'd95;
  localparam logic [7:0] COMMENT_RESET = 8'd59;

  // Per-line parse state (value accumulator travels separately)
  typedef struct packed {
    phase_t      phase;
    logic        pending_space;
    logic        is_negative;
    radix_t      radix;
    logic        digit_seen;
    logic        comment_present;
    logic [15:0] line_count;
  } parse_state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9);
  endfunction

  function automatic logic is_vspace(input logic [7:0] c);
    return (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

endpackage

>>> rtl/slp_ifs.sv
// Handshake channels of the parser: characters in, results out, register writes.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;
  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface slp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         ident_char;
  logic signed [31:0] value;
  logic               has_comment;
  logic [15:0]        line_number;
  modport source (output valid, output kind, output ident_char, output value,
                  output has_comment, output line_number, input ready);
  modport sink   (input valid, input kind, input ident_char, input value,
                  input has_comment, input line_number, output ready);
endinterface

interface slp_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/slp_value.sv
// Digit decode, shift-add accumulate step and final signed value of the parser.
module slp_value
  import slp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic [7:0]            ch,
  input  radix_t                radix,
  input  logic                  is_negative,
  input  logic [VALUE_BITS-1:0] acc,
  output logic                  digit_ok,
  output logic [VALUE_BITS-1:0] acc_step,
  output logic signed [31:0]    value
);

  logic [3:0]                   dval;
  logic                         dvalid;
  logic [VALUE_BITS-1:0]        scaled;
  logic signed [VALUE_BITS-1:0] signed_acc;

  // Decode the character as a hex digit
  always_comb begin
    dvalid = 1'b1;
    dval   = 4'd0;
    if (is_dec(ch)) begin
      dval = 4'(ch - 8'd48);
    end else if ((ch >= 8'd97) && (ch <= 8'd102)) begin
      dval = 4'(ch - 8'd87);
    end else if ((ch >= 8'd65) && (ch <= 8'd70)) begin
      dval = 4'(ch - 8'd55);
    end else begin
      dvalid = 1'b0;
    end
  end

  // Check the digit against the base and scale the accumulator
  always_comb begin
    case (radix)
      RADIX_HEX: begin
        digit_ok = dvalid;
        scaled   = acc << 4;
      end
      RADIX_BIN: begin
        digit_ok = dvalid && (dval < 4'd2);
        scaled   = acc << 1;
      end
      default: begin
        digit_ok = dvalid && (dval < 4'd10);
        scaled   = (acc << 3) + (acc << 1);
      end
    endcase
  end

  assign acc_step = scaled + VALUE_BITS'(dval);

  // Apply the sign, then sign-extend or truncate to 32 bits
  assign signed_acc = is_negative ? -acc : acc;
  assign value      = 32'(signed_acc);

endmodule

>>> rtl/slp_parse.sv
// Next-state and result logic for one character of the line parser.
module slp_parse
  import slp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic [7:0]            comment_char,
  input  logic                  ignore_unknown,
  input  logic [7:0]            ch,
  input  logic                  end_of_input,
  input  parse_state_t          st,
  input  logic [VALUE_BITS-1:0] acc,
  output parse_state_t          st_next,
  output logic [VALUE_BITS-1:0] acc_next,
  output logic                  halt_set,
  output logic                  res_valid,
  output kind_t                 res_kind,
  output logic [7:0]            res_ident,
  output logic signed [31:0]    res_value,
  output logic                  res_comment,
  output logic [15:0]           res_line
);

  logic                  digit_ok;
  logic [VALUE_BITS-1:0] acc_step;
  logic signed [31:0]    final_value;
  logic                  line_end;
  logic                  fail;
  kind_t                 fail_kind;
  logic                  define;
  logic                  take_digit;
  logic                  num_start;

  slp_value #(.VALUE_BITS(VALUE_BITS)) u_value (
    .ch          (ch),
    .radix       (st.radix),
    .is_negative (st.is_negative),
    .acc         (acc),
    .digit_ok    (digit_ok),
    .acc_step    (acc_step),
    .value       (final_value)
  );

  assign line_end = end_of_input || (ch == CH_NL);
  assign res_line = st.line_count + 16'd1;

  always_comb begin
    st_next     = st;
    acc_next    = acc;
    fail        = 1'b0;
    fail_kind   = K_SYNTAX;
    define      = 1'b0;
    take_digit  = 1'b0;
    num_start   = 1'b0;
    halt_set    = 1'b0;
    res_valid   = 1'b0;
    res_kind    = K_IDENT;
    res_ident   = 8'd0;
    res_value   = 32'sd0;
    res_comment = 1'b0;

    if (line_end) begin
      // Finish the line
      unique case (st.phase)
        PH_IDENT, PH_AFTER_ID, PH_COLON: begin
          fail      = 1'b1;
          fail_kind = K_MISS_EQ;
        end
        PH_EQ, PH_SIGN, PH_PREFIX: begin
          fail      = 1'b1;
          fail_kind = K_NUM_FMT;
        end
        PH_DIGITS, PH_AFTER_NUM, PH_COMMENT: begin
          define = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (st.phase)
        PH_START: begin
          if (is_blank(ch)) begin
          end else if (st.pending_space) begin
            if (!is_vspace(ch)) begin
              fail = 1'b1;
            end
          end else if (ch == comment_char) begin
            st_next.phase = PH_SKIP;
          end else if (is_vspace(ch)) begin
            st_next.pending_space = 1'b1;
          end else if (is_alpha(ch) || (ch == CH_UNDER)) begin
            st_next.phase = PH_IDENT;
            res_valid     = 1'b1;
            res_ident     = ch;
          end else begin
            fail = 1'b1;
          end
        end
        PH_IDENT: begin
          if (is_alpha(ch) || is_dec(ch) || (ch == CH_UNDER)) begin
            res_valid = 1'b1;
            res_ident = ch;
          end else if (is_blank(ch)) begin
            st_next.phase = PH_AFTER_ID;
          end else if (ch == CH_EQUALS) begin
            st_next.phase = PH_EQ;
          end else if (ch == CH_COLON) begin
            st_next.phase = PH_COLON;
          end else begin
            fail      = 1'b1;
            fail_kind = K_MISS_EQ;
          end
        end
        PH_AFTER_ID: begin
          if (is_blank(ch)) begin
          end else if (ch == CH_EQUALS) begin
            st_next.phase = PH_EQ;
          end else if (ch == CH_COLON) begin
            st_next.phase = PH_COLON;
          end else begin
            fail      = 1'b1;
            fail_kind = K_MISS_EQ;
          end
        end
        PH_COLON: begin
          if (ch == CH_EQUALS) begin
            st_next.phase = PH_EQ;
          end else begin
            fail      = 1'b1;
            fail_kind = K_MISS_EQ;
          end
        end
        PH_EQ: begin
          if (is_blank(ch)) begin
          end else if (ch == CH_MINUS) begin
            st_next.is_negative = 1'b1;
            st_next.phase       = PH_SIGN;
          end else if (ch == CH_PLUS) begin
            st_next.phase = PH_SIGN;
          end else begin
            num_start = 1'b1;
          end
        end
        PH_SIGN: begin
          num_start = 1'b1;
        end
        PH_PREFIX: begin
          if (digit_ok) begin
            take_digit = 1'b1;
          end else begin
            fail      = 1'b1;
            fail_kind = K_NUM_FMT;
          end
        end
        PH_DIGITS, PH_AFTER_NUM: begin
          if (st.pending_space) begin
            if (!is_blank(ch) && !is_vspace(ch)) begin
              fail      = 1'b1;
              fail_kind = K_TRAILING;
            end
          end else if ((st.phase == PH_DIGITS) && digit_ok) begin
            take_digit = 1'b1;
          end else if (is_blank(ch)) begin
            st_next.phase = PH_AFTER_NUM;
          end else if (ch == comment_char) begin
            st_next.phase = PH_COMMENT;
          end else if (is_vspace(ch)) begin
            st_next.pending_space = 1'b1;
          end else begin
            fail      = 1'b1;
            fail_kind = K_TRAILING;
          end
        end
        PH_COMMENT: begin
          if (!is_blank(ch) && !is_vspace(ch)) begin
            st_next.comment_present = 1'b1;
          end
        end
        default: ;
      endcase

      // Open the number: radix prefix or first decimal digit
      if (num_start) begin
        if (ch == CH_DOLLAR) begin
          st_next.radix = RADIX_HEX;
          st_next.phase = PH_PREFIX;
        end else if (ch == CH_PCT) begin
          st_next.radix = RADIX_BIN;
          st_next.phase = PH_PREFIX;
        end else if (is_dec(ch)) begin
          take_digit = 1'b1;
        end else begin
          fail      = 1'b1;
          fail_kind = K_NUM_FMT;
        end
      end

      // Advance the accumulator
      if (take_digit) begin
        acc_next           = acc_step;
        st_next.digit_seen = 1'b1;
        st_next.phase      = PH_DIGITS;
      end
    end

    // Report an error: drop the line or halt
    if (fail) begin
      st_next.phase = PH_SKIP;
      res_valid     = 1'b1;
      if (ignore_unknown) begin
        res_kind = K_DROPPED;
      end else begin
        res_kind = fail_kind;
        halt_set = 1'b1;
      end
    end

    if (define) begin
      res_valid   = 1'b1;
      res_kind    = K_DEFINED;
      res_value   = final_value;
      res_comment = st.comment_present;
    end

    // Start a new line
    if (line_end) begin
      st_next.phase           = PH_START;
      st_next.pending_space   = 1'b0;
      st_next.is_negative     = 1'b0;
      st_next.radix           = RADIX_DEC;
      st_next.digit_seen      = 1'b0;
      st_next.comment_present = 1'b0;
      st_next.line_count      = end_of_input ? 16'd0 : res_line;
      acc_next                = '0;
    end
  end

endmodule

>>> rtl/symbol_assignment_line_parser_core.sv
// A character is held in the input register, then its result goes to the result
// register. Throughput: one character per cycle unless results stall; the parse
// state and value shift-add settle in the single logic stage between the registers.
// Reset: rst (synchronous) returns to line start with line count zero, clears the
// halt flag, sets comment_char to ';' and ignore_unknown to 0, and empties both
// the input and result registers.
module symbol_assignment_line_parser_core
  import slp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  slp_in_if.sink     chars,
  slp_out_if.source  results,
  slp_cfg_if.sink    cfg
);

  logic                  in_vld;
  logic [7:0]            in_ch;
  logic                  in_eoi;
  logic                  go;

  parse_state_t          st;
  parse_state_t          st_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  halted;
  logic [7:0]            comment_char;
  logic                  ignore_unknown;

  logic                  halt_set;
  logic                  res_valid;
  kind_t                 res_kind;
  logic [7:0]            res_ident;
  logic signed [31:0]    res_value;
  logic                  res_comment;
  logic [15:0]           res_line;

  logic                  out_vld;

  // Process the held beat when the result register is free or draining
  assign go           = in_vld && (!out_vld || results.ready);
  assign chars.ready  = !in_vld || go;
  assign cfg.ready    = 1'b1;
  assign results.valid = out_vld;

  slp_parse #(.VALUE_BITS(VALUE_BITS)) u_parse (
    .comment_char   (comment_char),
    .ignore_unknown (ignore_unknown),
    .ch             (in_ch),
    .end_of_input   (in_eoi),
    .st             (st),
    .acc            (acc),
    .st_next        (st_next),
    .acc_next       (acc_next),
    .halt_set       (halt_set),
    .res_valid      (res_valid),
    .res_kind       (res_kind),
    .res_ident      (res_ident),
    .res_value      (res_value),
    .res_comment    (res_comment),
    .res_line       (res_line)
  );

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.ready) begin
      in_vld <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      in_ch  <= chars.ch;
      in_eoi <= chars.end_of_input;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comment_char   <= COMMENT_RESET;
      ignore_unknown <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COMMENT_CHAR: comment_char   <= cfg.data;
        REG_IGNORE:       ignore_unknown <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Advance parse state; hold everything once halted
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_START;
      st.pending_space   <= 1'b0;
      st.is_negative     <= 1'b0;
      st.radix           <= RADIX_DEC;
      st.digit_seen      <= 1'b0;
      st.comment_present <= 1'b0;
      st.line_count      <= 16'd0;
      acc                <= '0;
      halted             <= 1'b0;
    end else if (go && !halted) begin
      st     <= st_next;
      acc    <= acc_next;
      halted <= halt_set;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (go) begin
      out_vld <= res_valid && !halted;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
    if (go) begin
      results.kind        <= res_kind;
      results.ident_char  <= res_ident;
      results.value       <= res_value;
      results.has_comment <= res_comment;
      results.line_number <= res_line;
    end
  end

endmodule
